// ===== rtl/core/cmsia_pkg.sv =====
package cmsia_pkg;

   typedef enum logic [1:0] {
      KIND_ADD     = 2'd0,
      KIND_SUB     = 2'd1,
      KIND_MUL     = 2'd2,
      KIND_CONVERT = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      WIDTH_8  = 2'd0,
      WIDTH_16 = 2'd1,
      WIDTH_32 = 2'd2,
      WIDTH_64 = 2'd3
   } width_code_type;

   localparam int unsigned DATA_W = 64;
   localparam int unsigned HALF_W = 32;

   typedef struct packed {
      logic           valid;
      kind_type       kind;
      width_code_type twidth;
      logic           tsigned;
   } ctrl_type;

   typedef struct packed {
      logic              neg;
      logic [DATA_W-1:0] mag;
   } sm_type;

endpackage

// ===== rtl/core/checked_mixed_sign_int_alu.sv =====
// Channel   | Handshake          | Payload
// request   | start, busy        | req_kind, req_operand_a, req_operand_b, req_sign_mode,
//           |                    | req_target_width, req_target_signed
// response  | rsp_done (strobe)  | rsp_result, rsp_overflow
//
// One transaction per cycle; each result passes through the registered stages below, in order.
// Stages: operand decode, partial products and add/subtract, product combine,
// range check. The four 32x32 products set the stage depth.
// Reset clears only the valid bits. busy is always low: nothing stalls.
module checked_mixed_sign_int_alu
   import cmsia_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_kind,
   input  logic [DATA_W-1:0] req_operand_a,
   input  logic [DATA_W-1:0] req_operand_b,
   input  logic [1:0]        req_sign_mode,
   input  logic [1:0]        req_target_width,
   input  logic              req_target_signed,
   output logic              rsp_done,
   output logic [DATA_W-1:0] rsp_result,
   output logic              rsp_overflow
);

   ctrl_type          d_ctrl;
   sm_type            d_op_a;
   sm_type            d_op_b;
   ctrl_type          r_ctrl;
   logic              r_neg;
   logic              r_hi_nz;
   logic [DATA_W-1:0] r_lo;

   assign busy = 1'b0;

   cmsia_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .kind          (req_kind),
      .operand_a     (req_operand_a),
      .operand_b     (req_operand_b),
      .sign_mode     (req_sign_mode),
      .target_width  (req_target_width),
      .target_signed (req_target_signed),
      .ctrl          (d_ctrl),
      .op_a          (d_op_a),
      .op_b          (d_op_b)
   );

   cmsia_arith u_arith (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (d_ctrl),
      .op_a    (d_op_a),
      .op_b    (d_op_b),
      .r_ctrl  (r_ctrl),
      .r_neg   (r_neg),
      .r_hi_nz (r_hi_nz),
      .r_lo    (r_lo)
   );

   cmsia_check u_check (
      .clock    (clock),
      .reset    (reset),
      .r_ctrl   (r_ctrl),
      .r_neg    (r_neg),
      .r_hi_nz  (r_hi_nz),
      .r_lo     (r_lo),
      .done     (rsp_done),
      .result   (rsp_result),
      .overflow (rsp_overflow)
   );

endmodule

// ===== rtl/core/cmsia_decode.sv =====
module cmsia_decode
   import cmsia_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        kind,
   input  logic [DATA_W-1:0] operand_a,
   input  logic [DATA_W-1:0] operand_b,
   input  logic [1:0]        sign_mode,
   input  logic [1:0]        target_width,
   input  logic              target_signed,
   output ctrl_type          ctrl,
   output sm_type            op_a,
   output sm_type            op_b
);

   ctrl_type ctrl_ff, ctrl_in;
   sm_type   op_a_ff, op_a_in;
   sm_type   op_b_ff, op_b_in;
   logic     b_neg;

   always_comb begin
      ctrl_in.valid   = start;
      ctrl_in.kind    = kind_type'(kind);
      ctrl_in.twidth  = width_code_type'(target_width);
      ctrl_in.tsigned = target_signed;

      op_a_in.neg = sign_mode[1] & operand_a[DATA_W-1];
      op_a_in.mag = op_a_in.neg ? (~operand_a + 1'b1) : operand_a;

      b_neg       = sign_mode[0] & operand_b[DATA_W-1];
      op_b_in.mag = b_neg ? (~operand_b + 1'b1) : operand_b;
      op_b_in.neg = (kind_type'(kind) == KIND_SUB) ? ~b_neg : b_neg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else begin
         ctrl_ff.valid <= ctrl_in.valid;
      end
      ctrl_ff.kind    <= ctrl_in.kind;
      ctrl_ff.twidth  <= ctrl_in.twidth;
      ctrl_ff.tsigned <= ctrl_in.tsigned;
      op_a_ff         <= op_a_in;
      op_b_ff         <= op_b_in;
   end

   assign ctrl = ctrl_ff;
   assign op_a = op_a_ff;
   assign op_b = op_b_ff;

endmodule

// ===== rtl/core/cmsia_arith.sv =====
module cmsia_arith
   import cmsia_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  ctrl_type          ctrl,
   input  sm_type            op_a,
   input  sm_type            op_b,
   output ctrl_type          r_ctrl,
   output logic              r_neg,
   output logic              r_hi_nz,
   output logic [DATA_W-1:0] r_lo
);

   // stage two: partial products and add/subtract
   ctrl_type          s2_ctrl_ff, s2_ctrl_in;
   logic [DATA_W-1:0] p0_ff, p1_ff, p2_ff, p3_ff;
   logic [DATA_W-1:0] p0_in, p1_in, p2_in, p3_in;
   logic              s2_neg_ff, s2_neg_in;
   logic              s2_carry_ff, s2_carry_in;
   logic [DATA_W-1:0] s2_lo_ff, s2_lo_in;
   logic              s2_mneg_ff, s2_mneg_in;

   logic [DATA_W:0]   sum_ab;
   logic [DATA_W:0]   diff_ab;
   logic [DATA_W:0]   diff_ba;

   // stage three: combine
   ctrl_type          s3_ctrl_ff, s3_ctrl_in;
   logic              s3_neg_ff, s3_neg_in;
   logic              s3_hi_nz_ff, s3_hi_nz_in;
   logic [DATA_W-1:0] s3_lo_ff, s3_lo_in;

   logic [HALF_W+1:0] mid;
   logic [DATA_W-1:0] hi_sum;
   logic              neg_sel;
   logic              hi_nz_sel;

   always_comb begin
      s2_ctrl_in = ctrl;
      p0_in = DATA_W'(op_a.mag[HALF_W-1:0])      * DATA_W'(op_b.mag[HALF_W-1:0]);
      p1_in = DATA_W'(op_a.mag[HALF_W-1:0])      * DATA_W'(op_b.mag[DATA_W-1:HALF_W]);
      p2_in = DATA_W'(op_a.mag[DATA_W-1:HALF_W]) * DATA_W'(op_b.mag[HALF_W-1:0]);
      p3_in = DATA_W'(op_a.mag[DATA_W-1:HALF_W]) * DATA_W'(op_b.mag[DATA_W-1:HALF_W]);
      s2_mneg_in = op_a.neg ^ op_b.neg;

      sum_ab  = {1'b0, op_a.mag} + {1'b0, op_b.mag};
      diff_ab = {1'b0, op_a.mag} - {1'b0, op_b.mag};
      diff_ba = {1'b0, op_b.mag} - {1'b0, op_a.mag};

      if (ctrl.kind == KIND_CONVERT) begin
         s2_neg_in   = op_a.neg;
         s2_carry_in = 1'b0;
         s2_lo_in    = op_a.mag;
      end else if (op_a.neg == op_b.neg) begin
         s2_neg_in   = op_a.neg;
         s2_carry_in = sum_ab[DATA_W];
         s2_lo_in    = sum_ab[DATA_W-1:0];
      end else if (!diff_ab[DATA_W]) begin
         s2_neg_in   = op_a.neg;
         s2_carry_in = 1'b0;
         s2_lo_in    = diff_ab[DATA_W-1:0];
      end else begin
         s2_neg_in   = op_b.neg;
         s2_carry_in = 1'b0;
         s2_lo_in    = diff_ba[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctrl_ff.valid <= 1'b0;
      end else begin
         s2_ctrl_ff.valid <= s2_ctrl_in.valid;
      end
      s2_ctrl_ff.kind    <= s2_ctrl_in.kind;
      s2_ctrl_ff.twidth  <= s2_ctrl_in.twidth;
      s2_ctrl_ff.tsigned <= s2_ctrl_in.tsigned;
      p0_ff       <= p0_in;
      p1_ff       <= p1_in;
      p2_ff       <= p2_in;
      p3_ff       <= p3_in;
      s2_mneg_ff  <= s2_mneg_in;
      s2_neg_ff   <= s2_neg_in;
      s2_carry_ff <= s2_carry_in;
      s2_lo_ff    <= s2_lo_in;
   end

   always_comb begin
      s3_ctrl_in = s2_ctrl_ff;
      mid = (HALF_W+2)'(p0_ff[DATA_W-1:HALF_W])
          + (HALF_W+2)'(p1_ff[HALF_W-1:0])
          + (HALF_W+2)'(p2_ff[HALF_W-1:0]);
      hi_sum = p3_ff
             + DATA_W'(p1_ff[DATA_W-1:HALF_W])
             + DATA_W'(p2_ff[DATA_W-1:HALF_W])
             + DATA_W'(mid[HALF_W+1:HALF_W]);

      if (s2_ctrl_ff.kind == KIND_MUL) begin
         neg_sel   = s2_mneg_ff;
         hi_nz_sel = |hi_sum;
         s3_lo_in  = {mid[HALF_W-1:0], p0_ff[HALF_W-1:0]};
      end else begin
         neg_sel   = s2_neg_ff;
         hi_nz_sel = s2_carry_ff;
         s3_lo_in  = s2_lo_ff;
      end
      s3_hi_nz_in = hi_nz_sel;
      s3_neg_in   = neg_sel & (hi_nz_sel | (|s3_lo_in));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ctrl_ff.valid <= 1'b0;
      end else begin
         s3_ctrl_ff.valid <= s3_ctrl_in.valid;
      end
      s3_ctrl_ff.kind    <= s3_ctrl_in.kind;
      s3_ctrl_ff.twidth  <= s3_ctrl_in.twidth;
      s3_ctrl_ff.tsigned <= s3_ctrl_in.tsigned;
      s3_neg_ff   <= s3_neg_in;
      s3_hi_nz_ff <= s3_hi_nz_in;
      s3_lo_ff    <= s3_lo_in;
   end

   assign r_ctrl  = s3_ctrl_ff;
   assign r_neg   = s3_neg_ff;
   assign r_hi_nz = s3_hi_nz_ff;
   assign r_lo    = s3_lo_ff;

endmodule

// ===== rtl/core/cmsia_check.sv =====
module cmsia_check
   import cmsia_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  ctrl_type          r_ctrl,
   input  logic              r_neg,
   input  logic              r_hi_nz,
   input  logic [DATA_W-1:0] r_lo,
   output logic              done,
   output logic [DATA_W-1:0] result,
   output logic              overflow
);

   logic              done_ff, done_in;
   logic [DATA_W-1:0] result_ff, result_in;
   logic              overflow_ff, overflow_in;

   logic [DATA_W-1:0] ulimit;
   logic [DATA_W-1:0] half;
   logic              ovf;

   always_comb begin
      case (r_ctrl.twidth)
         WIDTH_8: begin
            ulimit = DATA_W'(64'h0000_0000_0000_00FF);
            half   = DATA_W'(64'h0000_0000_0000_0080);
         end
         WIDTH_16: begin
            ulimit = DATA_W'(64'h0000_0000_0000_FFFF);
            half   = DATA_W'(64'h0000_0000_0000_8000);
         end
         WIDTH_32: begin
            ulimit = DATA_W'(64'h0000_0000_FFFF_FFFF);
            half   = DATA_W'(64'h0000_0000_8000_0000);
         end
         default: begin
            ulimit = DATA_W'(64'hFFFF_FFFF_FFFF_FFFF);
            half   = DATA_W'(64'h8000_0000_0000_0000);
         end
      endcase

      if (r_hi_nz) begin
         ovf = 1'b1;
      end else if (!r_ctrl.tsigned) begin
         ovf = r_neg | (r_lo > ulimit);
      end else if (r_neg) begin
         ovf = r_lo > half;
      end else begin
         ovf = r_lo > (half - 1'b1);
      end

      done_in     = r_ctrl.valid;
      overflow_in = ovf;
      if (ovf) begin
         result_in = '0;
      end else if (r_neg) begin
         result_in = ~r_lo + 1'b1;
      end else begin
         result_in = r_lo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
      result_ff   <= result_in;
      overflow_ff <= overflow_in;
   end

   assign done     = done_ff;
   assign result   = result_ff;
   assign overflow = overflow_ff;

endmodule

// ===== tb/checked_mixed_sign_int_alu_tb.sv =====
module checked_mixed_sign_int_alu_tb;
   import cmsia_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] MODE_UU = 2'd0;
   localparam logic [1:0] MODE_US = 2'd1;
   localparam logic [1:0] MODE_SU = 2'd2;
   localparam logic [1:0] MODE_SS = 2'd3;

   localparam int unsigned RANDOM_OPS     = 800;
   localparam int unsigned MAX_GAP        = 10;
   localparam int unsigned WATCHDOG_LIMIT = 1000;
   localparam int unsigned DRAIN_CYCLES   = 12;
   localparam int unsigned REPORT_LIMIT   = 10;

   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;

   typedef struct {
      kind_type       kind;
      logic [63:0]    a;
      logic [63:0]    b;
      logic [1:0]     mode;
      width_code_type twidth;
      logic           tsigned;
      int unsigned    gap;
   } alu_op_type;

   typedef struct {
      logic [63:0] result;
      logic        overflow;
   } alu_res_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [1:0]        req_kind = 2'd0;
   logic [DATA_W-1:0] req_operand_a = '0;
   logic [DATA_W-1:0] req_operand_b = '0;
   logic [1:0]        req_sign_mode = 2'd0;
   logic [1:0]        req_target_width = 2'd0;
   logic              req_target_signed = 1'b0;
   logic              rsp_done;
   logic [DATA_W-1:0] rsp_result;
   logic              rsp_overflow;

   alu_op_type  pending_ops[$];
   alu_res_type expected_results[$];
   alu_op_type  cur_op;
   logic        next_start;
   int unsigned gap_left;
   int unsigned accepted_count = 0;
   int unsigned total_ops = 0;
   int unsigned error_count = 0;
   int unsigned idle_cycles = 0;

   checked_mixed_sign_int_alu i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_operand_a     (req_operand_a),
      .req_operand_b     (req_operand_b),
      .req_sign_mode     (req_sign_mode),
      .req_target_width  (req_target_width),
      .req_target_signed (req_target_signed),
      .rsp_done          (rsp_done),
      .rsp_result        (rsp_result),
      .rsp_overflow      (rsp_overflow)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic alu_res_type checked_result(alu_op_type op);
      alu_res_type  res;
      logic         a_neg;
      logic         b_neg;
      logic         r_neg;
      logic [127:0] a_mag;
      logic [127:0] b_mag;
      logic [127:0] r_mag;
      logic [127:0] half;
      int unsigned  width;
      a_neg = op.mode[1] && op.a[63];
      b_neg = op.mode[0] && op.b[63];
      a_mag = {64'd0, a_neg ? 64'd0 - op.a : op.a};
      b_mag = {64'd0, b_neg ? 64'd0 - op.b : op.b};
      if (op.kind == KIND_SUB) b_neg = !b_neg;
      case (op.kind)
         KIND_ADD, KIND_SUB: begin
            if (a_neg == b_neg) begin
               r_neg = a_neg;
               r_mag = a_mag + b_mag;
            end else if (a_mag >= b_mag) begin
               r_neg = a_neg;
               r_mag = a_mag - b_mag;
            end else begin
               r_neg = b_neg;
               r_mag = b_mag - a_mag;
            end
         end
         KIND_MUL: begin
            r_neg = a_neg ^ b_neg;
            r_mag = a_mag * b_mag;
         end
         default: begin
            r_neg = a_neg;
            r_mag = a_mag;
         end
      endcase
      if (r_mag == 128'd0) r_neg = 1'b0;
      width = 8 << op.twidth;
      half = 128'd1 << (width - 1);
      res.result = 64'd0;
      if (r_mag[127:64] != 64'd0) begin
         res.overflow = 1'b1;
      end else if (!op.tsigned) begin
         res.overflow = r_neg || (r_mag > ((128'd1 << width) - 128'd1));
         if (!res.overflow) res.result = r_mag[63:0];
      end else if (r_neg) begin
         res.overflow = r_mag > half;
         if (!res.overflow) res.result = 64'd0 - r_mag[63:0];
      end else begin
         res.overflow = r_mag >= half;
         if (!res.overflow) res.result = r_mag[63:0];
      end
      return res;
   endfunction

   function automatic logic [63:0] pick_operand();
      logic [63:0] v;
      int unsigned sh;
      sh = $urandom_range(0, 63);
      case ($urandom_range(0, 6))
         0, 1: v = {$urandom, $urandom};
         2: v = 64'($urandom_range(0, 300));
         3: v = 64'd0 - 64'($urandom_range(0, 300));
         4: v = (64'd1 << sh) - 64'd2 + 64'($urandom_range(0, 3));
         5: v = 64'd0 - (64'd1 << sh) - 64'd1 + 64'($urandom_range(0, 3));
         default: v = {{32{$urandom_range(0, 1) == 1}}, 32'($urandom)};
      endcase
      return v;
   endfunction

   task automatic add_op(kind_type kind, logic [63:0] a, logic [63:0] b, logic [1:0] mode,
                         width_code_type twidth, logic tsigned, int unsigned gap);
      alu_op_type op;
      op.kind = kind;
      op.a = a;
      op.b = b;
      op.mode = mode;
      op.twidth = twidth;
      op.tsigned = tsigned;
      op.gap = gap;
      pending_ops.push_back(op);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
      end else begin
         next_start = start;
         if (start && !busy) begin
            expected_results.push_back(checked_result(cur_op));
            accepted_count++;
            next_start = 1'b0;
         end
         if (!next_start && pending_ops.size() > 0) begin
            if (gap_left < pending_ops[0].gap) begin
               gap_left++;
            end else begin
               cur_op = pending_ops.pop_front();
               gap_left = 0;
               req_kind <= cur_op.kind;
               req_operand_a <= cur_op.a;
               req_operand_b <= cur_op.b;
               req_sign_mode <= cur_op.mode;
               req_target_width <= cur_op.twidth;
               req_target_signed <= cur_op.tsigned;
               next_start = 1'b1;
            end
         end
         start <= next_start;
      end
   end

   always @(posedge clock) begin
      alu_res_type exp_res;
      if (!reset && rsp_done) begin
         if (expected_results.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("unexpected transaction: result %h overflow %b",
                        rsp_result, rsp_overflow);
         end else begin
            exp_res = expected_results.pop_front();
            if (rsp_result !== exp_res.result || rsp_overflow !== exp_res.overflow) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("mismatch: expected result %h overflow %b, got result %h overflow %b",
                           exp_res.result, exp_res.overflow, rsp_result, rsp_overflow);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_done) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      logic burst;
      int unsigned w;
      logic [63:0] lim;
      add_op(KIND_ADD, ALL_ONES, ALL_ONES, MODE_UU, WIDTH_64, 1'b0, 0);
      add_op(KIND_ADD, 64'd0, 64'd0, MODE_SS, WIDTH_8, 1'b1, 0);
      add_op(KIND_SUB, 64'd0, 64'd1, MODE_UU, WIDTH_64, 1'b0, 0);
      add_op(KIND_SUB, 64'd0, 64'd1, MODE_UU, WIDTH_64, 1'b1, 2);
      add_op(KIND_SUB, ALL_ONES, ALL_ONES, MODE_SS, WIDTH_8, 1'b0, 0);
      add_op(KIND_MUL, MOST_NEG, ALL_ONES, MODE_SS, WIDTH_64, 1'b1, 0);
      add_op(KIND_MUL, MOST_NEG, ALL_ONES, MODE_SS, WIDTH_64, 1'b0, 0);
      add_op(KIND_MUL, ALL_ONES, ALL_ONES, MODE_UU, WIDTH_64, 1'b0, 1);
      add_op(KIND_MUL, ALL_ONES, 64'd5, MODE_SU, WIDTH_16, 1'b1, 0);
      add_op(KIND_ADD, 64'd127, 64'd0, MODE_US, WIDTH_8, 1'b1, 0);
      add_op(KIND_ADD, 64'd127, 64'd1, MODE_SS, WIDTH_8, 1'b1, 3);
      add_op(KIND_CONVERT, 64'hFFFF_FFFF_FFFF_FF80, ALL_ONES, MODE_SU, WIDTH_8, 1'b1, 0);
      add_op(KIND_CONVERT, 64'hFFFF_FFFF_FFFF_FF7F, 64'd0, MODE_SS, WIDTH_8, 1'b1, 0);
      add_op(KIND_CONVERT, MOST_NEG, ALL_ONES, MODE_US, WIDTH_64, 1'b1, 0);
      add_op(KIND_CONVERT, MOST_NEG, 64'd7, MODE_SU, WIDTH_64, 1'b1, 0);
      for (w = 0; w < 4; w++) begin
         lim = (w == 3) ? ALL_ONES : (64'd1 << (8 << w)) - 64'd1;
         add_op(KIND_CONVERT, lim, 64'd0, MODE_UU, width_code_type'(w), 1'b0, 0);
         add_op(KIND_CONVERT, lim, 64'd0, MODE_UU, width_code_type'(w), 1'b1, 0);
         add_op(KIND_ADD, lim, 64'd1, MODE_UU, width_code_type'(w), 1'b0, 0);
      end
      burst = 1'b0;
      for (int unsigned n = 0; n < RANDOM_OPS; n++) begin
         if (n % 40 == 0) burst = ($urandom_range(0, 3) == 0);
         add_op(kind_type'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                2'($urandom_range(0, 3)), width_code_type'($urandom_range(0, 3)),
                1'($urandom_range(0, 1)), burst ? 0 : $urandom_range(0, MAX_GAP));
      end
      total_ops = pending_ops.size();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      while (accepted_count < total_ops || expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/cmsia_pkg.sv
rtl/core/cmsia_decode.sv
rtl/core/cmsia_arith.sv
rtl/core/cmsia_check.sv
rtl/core/checked_mixed_sign_int_alu.sv
tb/checked_mixed_sign_int_alu_tb.sv
